// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MMA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define MMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/mma_pkg.sv =====
// shared types and sizing constants of the multichannel moving average unit
// no dependencies
package mma_pkg;

    // sizing
    localparam int CHANNELS   = 8;
    localparam int WINDOW     = 16;
    localparam int CH_W       = 3;
    localparam int SMP_W      = 12;
    localparam int CHN_CMP_W  = 5;
    localparam int MEM_CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int COUNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W      = SMP_W + COUNT_W;
    localparam int HADDR_W    = MEM_CH_W + SLOT_W;
    localparam int HIST_DEPTH = 1 << HADDR_W;
    localparam int SUM_DEPTH  = 1 << MEM_CH_W;

    // channel payloads
    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] sample;
    } sample_t;

    typedef struct packed {
        logic [CH_W-1:0]  out_channel;
        logic [SMP_W-1:0] average;
    } result_t;

    // state memory read request
    typedef struct packed {
        logic                en;
        logic [MEM_CH_W-1:0] ch;
        logic [SLOT_W-1:0]   slot;
    } mem_rd_t;

    // state memory write request
    typedef struct packed {
        logic                en;
        logic [MEM_CH_W-1:0] ch;
        logic [SLOT_W-1:0]   slot;
        logic [SMP_W-1:0]    hist;
        logic [SUM_W-1:0]    sum;
    } mem_wr_t;

endpackage

// ===== rtl/core/mma_state_mem.sv =====
// history ring and running sum memories with a clearing pass after reset
// depends on mma_pkg
module mma_state_mem (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mma_pkg::mem_rd_t                   rd,
    input  mma_pkg::mem_wr_t                   wr,
    output logic [mma_pkg::SMP_W-1:0]          hist_q,
    output logic [mma_pkg::SUM_W-1:0]          sum_q,
    output logic                               busy
);

    logic [mma_pkg::SMP_W-1:0]   hist_mem [mma_pkg::HIST_DEPTH];
    logic [mma_pkg::SUM_W-1:0]   sum_mem  [mma_pkg::SUM_DEPTH];
    logic [mma_pkg::HADDR_W-1:0] clr_addr_reg;
    logic [mma_pkg::HADDR_W-1:0] clr_addr_next;
    logic                        clr_busy_reg;
    logic                        clr_busy_next;

    // clearing sweep, one history entry per cycle
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // write port, the sweep takes priority
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            hist_mem[clr_addr_reg]                      <= '0;
            sum_mem[clr_addr_reg[mma_pkg::MEM_CH_W-1:0]] <= '0;
        end
        else if (wr.en)
        begin
            hist_mem[{wr.ch, wr.slot}] <= wr.hist;
            sum_mem[wr.ch]             <= wr.sum;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            hist_q <= hist_mem[{rd.ch, rd.slot}];
            sum_q  <= sum_mem[rd.ch];
        end
    end

    assign busy = clr_busy_reg;

endmodule

// ===== rtl/core/mma_div.sv =====
// restoring serial divider, one quotient bit per cycle
// depends on mma_pkg
module mma_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mma_pkg::SUM_W-1:0]     dividend,
    input  logic [mma_pkg::COUNT_W-1:0]   divisor,
    output logic [mma_pkg::SMP_W-1:0]     quotient,
    output logic                          done
);

    localparam int STEP_W = $clog2(mma_pkg::SUM_W + 1);

    logic [mma_pkg::SUM_W-1:0]   dq_reg;
    logic [mma_pkg::SUM_W-1:0]   dq_next;
    logic [mma_pkg::COUNT_W-1:0] rem_reg;
    logic [mma_pkg::COUNT_W-1:0] rem_next;
    logic [mma_pkg::COUNT_W-1:0] dvs_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [STEP_W-1:0]           step_next;
    logic                        run_reg;
    logic                        run_next;
    logic                        done_reg;
    logic                        done_next;
    logic [mma_pkg::COUNT_W:0]   rem_sh;
    logic [mma_pkg::COUNT_W:0]   rem_sub;

    // trial subtraction of one step
    always_comb
    begin
        rem_sh  = {rem_reg, dq_reg[mma_pkg::SUM_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = done_reg;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            step_next = STEP_W'(mma_pkg::SUM_W);
            run_next  = 1'b1;
            done_next = 1'b0;
        end
        else if (run_reg)
        begin
            if (!rem_sub[mma_pkg::COUNT_W])
            begin
                rem_next = rem_sub[mma_pkg::COUNT_W-1:0];
                dq_next  = {dq_reg[mma_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[mma_pkg::COUNT_W-1:0];
                dq_next  = {dq_reg[mma_pkg::SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = dq_reg[mma_pkg::SMP_W-1:0];
    assign done     = done_reg;

endmodule

// ===== rtl/core/multichannel_moving_average_unit.sv =====
// top level of the multichannel moving average unit: control sequencer and result register
// depends on mma_pkg, mma_state_mem and mma_div
//
// Per-channel boxcar average over the last WINDOW samples. After reset the history and
// running-sum memories are swept to zero, one entry per cycle (128 entries at 8 channels
// and a 16-deep window); sample_stall stays high during the sweep. Items are handled one
// at a time: the channel's history entry and sum are read as the item is accepted, then
// updated and written back, then the quotient is formed in the serial divider, and then
// the result moves to the output register. The divider, and a stalled output register,
// set the rate. A finished result waits in the output register while the next sample is
// already being taken. A channel number at or above CHANNELS leaves the state untouched
// and returns an average of zero.
module multichannel_moving_average_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  mma_pkg::sample_t sample_data,
    output logic             result_valid,
    input  logic             result_stall,
    output mma_pkg::result_t result_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [mma_pkg::CH_W-1:0]    ch_reg;
    logic [mma_pkg::SMP_W-1:0]   smp_reg;
    logic                        bad_reg;
    logic [mma_pkg::SLOT_W-1:0]  slot_reg;
    logic [mma_pkg::SLOT_W-1:0]  slot_next;
    logic                        filled_reg;
    logic                        filled_next;
    logic                        result_valid_reg;
    logic                        result_valid_next;
    mma_pkg::result_t            result_reg;

    logic                        accept;
    logic                        in_range;
    logic                        is_last_ch;
    logic                        out_free;
    logic                        load_out;
    logic [mma_pkg::SLOT_W:0]    slot_inc;
    logic [mma_pkg::SUM_W-1:0]   new_sum;
    logic [mma_pkg::COUNT_W-1:0] count;
    mma_pkg::mem_rd_t            mem_rd;
    mma_pkg::mem_wr_t            mem_wr;
    logic [mma_pkg::SMP_W-1:0]   hist_q;
    logic [mma_pkg::SUM_W-1:0]   sum_q;
    logic                        mem_busy;
    logic                        div_start;
    logic [mma_pkg::SMP_W-1:0]   quotient;
    logic                        div_done;

    mma_state_mem u_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd     (mem_rd),
        .wr     (mem_wr),
        .hist_q (hist_q),
        .sum_q  (sum_q),
        .busy   (mem_busy)
    );

    mma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (new_sum),
        .divisor  (count),
        .quotient (quotient),
        .done     (div_done)
    );

    // input handshake, one item in flight
    assign sample_stall = (state_reg != ST_IDLE) || mem_busy;
    assign accept       = sample_valid && !sample_stall;
    assign in_range     = mma_pkg::CHN_CMP_W'(sample_data.channel)
                          < mma_pkg::CHN_CMP_W'(mma_pkg::CHANNELS);
    assign is_last_ch   = mma_pkg::CHN_CMP_W'(ch_reg)
                          == mma_pkg::CHN_CMP_W'(mma_pkg::CHANNELS - 1);

    // read the channel's entry at the shared slot
    always_comb
    begin
        mem_rd.en   = accept && in_range;
        mem_rd.ch   = mma_pkg::MEM_CH_W'(sample_data.channel);
        mem_rd.slot = slot_reg;
    end

    // running sum update and divisor
    always_comb
    begin
        new_sum = sum_q - mma_pkg::SUM_W'(hist_q) + mma_pkg::SUM_W'(smp_reg);
        if (filled_reg)
        begin
            count = mma_pkg::COUNT_W'(mma_pkg::WINDOW);
        end
        else
        begin
            count = mma_pkg::COUNT_W'(slot_reg) + 1'b1;
        end
    end

    // write back, the next read cannot start before this completes
    always_comb
    begin
        mem_wr.en   = (state_reg == ST_UPD);
        mem_wr.ch   = mma_pkg::MEM_CH_W'(ch_reg);
        mem_wr.slot = slot_reg;
        mem_wr.hist = smp_reg;
        mem_wr.sum  = new_sum;
    end

    assign div_start = (state_reg == ST_UPD);
    assign out_free  = !result_valid_reg || !result_stall;
    assign load_out  = (state_reg == ST_DIV) && (bad_reg || div_done) && out_free;

    // slot pointer advances after the highest channel
    always_comb
    begin
        slot_inc    = {1'b0, slot_reg} + 1'b1;
        slot_next   = slot_reg;
        filled_next = filled_reg;
        if ((state_reg == ST_UPD) && is_last_ch)
        begin
            if (slot_inc >= (mma_pkg::SLOT_W + 1)'(mma_pkg::WINDOW))
            begin
                slot_next   = '0;
                filled_next = 1'b1;
            end
            else
            begin
                slot_next = slot_inc[mma_pkg::SLOT_W-1:0];
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_range ? ST_UPD : ST_DIV;
                end
            end
            ST_UPD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_out)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_reg         <= '0;
            filled_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            bad_reg          <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            slot_reg         <= slot_next;
            filled_reg       <= filled_next;
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                bad_reg <= !in_range;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= sample_data.channel;
            smp_reg <= sample_data.sample;
        end
        if (load_out)
        begin
            result_reg.out_channel <= ch_reg;
            result_reg.average     <= bad_reg ? '0 : quotient;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule

// ===== rtl/core/mma_checker.sv =====
// port-level checker for the multichannel moving average unit, bound to the top level
// depends on mma_pkg and assert_macros.svh
`include "assert_macros.svh"

module mma_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_stall,
    input logic             result_valid,
    input logic             result_stall,
    input mma_pkg::result_t result_data
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       in_xfer;
    logic       out_xfer;
    logic       out_held;

    assign in_xfer  = sample_valid && !sample_stall;
    assign out_xfer = result_valid && !result_stall;
    assign out_held = result_valid && result_stall;

    // items accepted but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer && !out_xfer)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!in_xfer && out_xfer)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a stalled result holds
    `MMA_ASSERT_NEXT(a_result_hold, clk, rst_n, out_held, result_valid && $stable(result_data))
    // one sample at a time: stall right after a transfer
    `MMA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_xfer, sample_stall)
    // no result without an outstanding sample
    `MMA_ASSERT_NOW(a_no_extra_result, clk, rst_n, result_valid, pend_reg != 2'd0)
    // at most one finished and one working item
    `MMA_ASSERT_NOW(a_pending_bound, clk, rst_n, 1'b1, pend_reg != 2'd3)

endmodule

bind multichannel_moving_average_unit mma_checker u_mma_checker (.*);
